// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge, reset included
`define SFR_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// property checked only outside reset
`define SFR_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- hdl/sfr_pkg.sv -----
// package with types and constants of the spi flash read slave
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int unsigned ADDR_BITS_DEF = 16;
   localparam int unsigned SPI_ADDR_W    = 24;

   localparam logic [7:0] CMD_READ = 8'h03;

   // byte positions inside one transaction
   localparam logic [2:0] BYTE_CMD     = 3'd0;
   localparam logic [2:0] BYTE_ADDR_HI = 3'd1;
   localparam logic [2:0] BYTE_ADDR_MD = 3'd2;
   localparam logic [2:0] BYTE_ADDR_LO = 3'd3;
   localparam logic [2:0] BYTE_DATA    = 3'd4;

   localparam logic [2:0] BIT_LAST = 3'd7;

   typedef struct packed {
      logic                  mode;
      logic                  chip_select_n;
      logic                  spi_clock;
      logic                  mosi_bit;
      logic [SPI_ADDR_W-1:0] load_address;
      logic [7:0]            load_byte;
   } req_item_type;

endpackage

// ----- hdl/sfr_if.sv -----
// valid/ready channel interfaces of the spi flash read slave
`timescale 1ns / 1ps

interface sfr_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic        chip_select_n;
   logic        spi_clock;
   logic        mosi_bit;
   logic [23:0] load_address;
   logic [7:0]  load_byte;

   modport source (output valid, mode, chip_select_n, spi_clock, mosi_bit,
                   load_address, load_byte, input ready);
   modport sink   (input valid, mode, chip_select_n, spi_clock, mosi_bit,
                   load_address, load_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic valid;
   logic ready;
   logic miso_bit;

   modport source (output valid, miso_bit, input ready);
   modport sink   (input valid, miso_bit, output ready);
endinterface

// ----- hdl/sfr_ram.sv -----
// generic single port ram with registered read
`timescale 1ns / 1ps

module sfr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sfr_core.sv -----
// pin edge detection, shift registers and read command sequencing
`timescale 1ns / 1ps

module sfr_core import sfr_pkg::*; #(
   parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  req_item_type         item,
   input  logic [7:0]           ram_rd_data,
   output logic                 ram_wr_en,
   output logic                 ram_rd_en,
   output logic [ADDR_BITS-1:0] ram_addr,
   output logic [7:0]           ram_wr_data,
   output logic                 miso_next
);

   logic [2:0]            bit_cnt_ff,  bit_cnt_in;
   logic [2:0]            byte_cnt_ff, byte_cnt_in;
   logic [SPI_ADDR_W-1:0] rd_addr_ff,  rd_addr_in;
   logic [7:0]            shift_in_ff, shift_in_in;
   logic [7:0]            cmd_ff,      cmd_in;
   logic [7:0]            shift_out_ff, shift_out_in;
   logic                  use_ram_ff,  use_ram_in;
   logic                  prev_clk_ff, prev_clk_in;
   logic                  prev_sel_ff, prev_sel_in;
   logic                  miso_ff,     miso_in;

   logic [7:0]            out_byte;
   logic [7:0]            shift_in_new;
   logic [SPI_ADDR_W-1:0] addr_merged;
   logic                  sel_rise;
   logic                  clk_rise;
   logic                  clk_fall;
   logic                  pin_step;

   // output byte is the ram data right after a fetch
   assign out_byte     = use_ram_ff ? ram_rd_data : shift_out_ff;
   assign shift_in_new = {shift_in_ff[6:0], item.mosi_bit};
   assign pin_step     = step && !item.mode;
   assign sel_rise     = !prev_sel_ff && item.chip_select_n;
   assign clk_rise     = !prev_clk_ff && item.spi_clock;
   assign clk_fall     = prev_clk_ff && !item.spi_clock;

   always_comb begin
      unique case (byte_cnt_ff)
         BYTE_ADDR_HI: addr_merged = rd_addr_ff | {shift_in_new, 16'h0000};
         BYTE_ADDR_MD: addr_merged = rd_addr_ff | {8'h00, shift_in_new, 8'h00};
         BYTE_ADDR_LO: addr_merged = rd_addr_ff | {16'h0000, shift_in_new};
         default:      addr_merged = rd_addr_ff;
      endcase
   end

   always_comb begin
      bit_cnt_in   = bit_cnt_ff;
      byte_cnt_in  = byte_cnt_ff;
      rd_addr_in   = rd_addr_ff;
      shift_in_in  = shift_in_ff;
      cmd_in       = cmd_ff;
      shift_out_in = shift_out_ff;
      use_ram_in   = use_ram_ff;
      prev_clk_in  = prev_clk_ff;
      prev_sel_in  = prev_sel_ff;
      miso_in      = miso_ff;
      ram_wr_en    = step && item.mode;
      ram_rd_en    = 1'b0;
      ram_addr     = item.load_address[ADDR_BITS-1:0];
      ram_wr_data  = item.load_byte;
      if (pin_step) begin
         prev_clk_in = item.spi_clock;
         prev_sel_in = item.chip_select_n;
         priority if (sel_rise) begin
            bit_cnt_in  = '0;
            byte_cnt_in = BYTE_CMD;
         end else if (clk_rise && !item.chip_select_n) begin
            shift_in_in  = shift_in_new;
            shift_out_in = {out_byte[6:0], 1'b0};
            use_ram_in   = 1'b0;
            bit_cnt_in   = bit_cnt_ff + 3'd1;
            if (bit_cnt_ff == BIT_LAST) begin
               shift_out_in = '0;
               bit_cnt_in   = '0;
               if (byte_cnt_ff == BYTE_CMD) begin
                  rd_addr_in = '0;
                  cmd_in     = shift_in_new;
               end else if (cmd_ff == CMD_READ) begin
                  rd_addr_in = addr_merged;
                  if (byte_cnt_ff >= BYTE_ADDR_LO) begin
                     ram_rd_en  = 1'b1;
                     ram_addr   = addr_merged[ADDR_BITS-1:0];
                     use_ram_in = 1'b1;
                     rd_addr_in = addr_merged + SPI_ADDR_W'(1);
                  end
               end
               if (byte_cnt_ff != BYTE_DATA) begin
                  byte_cnt_in = byte_cnt_ff + 3'd1;
               end
            end
         end else if (clk_fall && !item.chip_select_n) begin
            miso_in = out_byte[7];
         end else begin
            miso_in = miso_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff   <= '0;
         byte_cnt_ff  <= BYTE_CMD;
         rd_addr_ff   <= '0;
         shift_in_ff  <= '0;
         cmd_ff       <= '0;
         shift_out_ff <= '0;
         use_ram_ff   <= 1'b0;
         prev_clk_ff  <= 1'b0;
         prev_sel_ff  <= 1'b1;
         miso_ff      <= 1'b0;
      end else begin
         bit_cnt_ff   <= bit_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
         rd_addr_ff   <= rd_addr_in;
         shift_in_ff  <= shift_in_in;
         cmd_ff       <= cmd_in;
         shift_out_ff <= shift_out_in;
         use_ram_ff   <= use_ram_in;
         prev_clk_ff  <= prev_clk_in;
         prev_sel_ff  <= prev_sel_in;
         miso_ff      <= miso_in;
      end
   end

   assign miso_next = miso_in;

endmodule

// ----- hdl/spi_flash_read_slave.sv -----
// top level of the spi flash read slave
//
//   channel  dir  payload                                             accept
//   req_if   in   mode, chip_select_n, spi_clock, mosi_bit,           valid && ready
//                 load_address, load_byte
//   rsp_if   out  miso_bit                                            valid && ready
//
// one item per clock cycle sustained while rsp_if.ready stays high, set by the single step
// of the core logic; an accepted item passes through the input register, then the
// result register
// synchronous reset clears control state, the flash store keeps its contents
// a stalled result holds the input register, which then drops ready
`timescale 1ns / 1ps

module spi_flash_read_slave import sfr_pkg::*; #(
   parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   sfr_req_if.sink     req_if,
   sfr_rsp_if.source   rsp_if
);

   localparam int unsigned STORE_DEPTH = 2 ** ADDR_BITS;

   logic                 in_valid_ff,  in_valid_in;
   req_item_type         in_item_ff,   in_item_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_miso_ff;

   logic                 req_accept;
   logic                 advance;
   logic                 miso_next;
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [ADDR_BITS-1:0] ram_addr;
   logic [7:0]           ram_wr_data;
   logic [7:0]           ram_rd_data;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_accept = req_if.valid && req_if.ready;

   assign in_item_in = '{
      mode:          req_if.mode,
      chip_select_n: req_if.chip_select_n,
      spi_clock:     req_if.spi_clock,
      mosi_bit:      req_if.mosi_bit,
      load_address:  req_if.load_address,
      load_byte:     req_if.load_byte
   };

   always_comb begin
      priority if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      priority if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         out_miso_ff <= miso_next;
      end
   end

   sfr_core #(
      .ADDR_BITS (ADDR_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (in_item_ff),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_rd_en   (ram_rd_en),
      .ram_addr    (ram_addr),
      .ram_wr_data (ram_wr_data),
      .miso_next   (miso_next)
   );

   sfr_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   assign req_if.ready    = !in_valid_ff || advance;
   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.miso_bit = out_miso_ff;

endmodule

// ----- hdl/sfr_checker.sv -----
// port level checks of the spi flash read slave and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic miso_bit
);

   `SFR_ASSERT(a_reset_empty, clock, reset |=> !rsp_valid && req_ready, "result seen after reset")
   `SFR_ASSERT_RST(a_empty_ready, clock, reset, !rsp_valid |-> req_ready, "stall with empty result")
   `SFR_ASSERT_RST(a_idle_drain, clock, reset, !rsp_valid && !req_ready |-> 1'b0, "input blocked")
   `SFR_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(miso_bit), "stalled item changed")

endmodule

bind spi_flash_read_slave sfr_checker u_sfr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .miso_bit  (rsp_if.miso_bit)
);
